FILE: rtl/ecp_pkg.sv
package ecp_pkg;

    // default sizes
    localparam int FIELD_BITS_DEF  = 16;
    localparam int SCALAR_BITS_DEF = 16;

    // configuration registers
    localparam int              CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;
    localparam int              MOD_RESET   = 17;

    // operation field of a request
    localparam logic OPER_ADD = 1'b0;
    localparam logic OPER_MUL = 1'b1;

    // datapath command codes
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_ADD    = 4'd3;
    localparam logic [3:0] OP_SUB    = 4'd4;
    localparam logic [3:0] OP_MOV    = 4'd5;
    localparam logic [3:0] OP_UINF   = 4'd6;
    localparam logic [3:0] OP_UFIN   = 4'd7;
    localparam logic [3:0] OP_UFROMW = 4'd8;
    localparam logic [3:0] OP_SETWU  = 4'd9;
    localparam logic [3:0] OP_SETWQ  = 4'd10;
    localparam logic [3:0] OP_LDE    = 4'd11;
    localparam logic [3:0] OP_SHE    = 4'd12;
    localparam logic [3:0] OP_SHK    = 4'd13;
    localparam logic [3:0] OP_OUT    = 4'd14;

    // working register selects
    localparam logic [3:0] R_UX   = 4'd0;
    localparam logic [3:0] R_UY   = 4'd1;
    localparam logic [3:0] R_WX   = 4'd2;
    localparam logic [3:0] R_WY   = 4'd3;
    localparam logic [3:0] R_QX   = 4'd4;
    localparam logic [3:0] R_QY   = 4'd5;
    localparam logic [3:0] R_A    = 4'd6;
    localparam logic [3:0] R_S    = 4'd7;
    localparam logic [3:0] R_T0   = 4'd8;
    localparam logic [3:0] R_T1   = 4'd9;
    localparam logic [3:0] R_ONE  = 4'd10;
    localparam logic [3:0] R_ZERO = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] dst;
        logic [3:0] sa;
        logic [3:0] sb;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic u_inf;
        logic w_inf;
        logic eqx;
        logic eqy;
        logic uy_zero;
        logic p_small;
        logic e_msb;
        logic k_msb;
    } t_stat;

endpackage

FILE: rtl/ec_point_add_scalar_mult.sv
// Affine point addition and scalar multiplication on y^2 = x^3 + ax + b over
// the integers mod p (p and a from the configuration registers, index 0 is
// curve_a and index 1 is modulus). A request is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with o_done high,
// and it must be captured then since the receiver cannot stall it. Infinity is
// carried as o_r_inf with zero coordinates. All field products run on one
// bit-serial modular multiplier; the inversion inside each point addition
// uses up to 2*FIELD_BITS products, and a scalar multiply runs up to
// 2*SCALAR_BITS additions, fewer for sparse scalars. Configuration writes
// are taken in any cycle but must be made while busy is low.
module ec_point_add_scalar_mult import ecp_pkg::*; #(
    parameter int FIELD_BITS  = FIELD_BITS_DEF,
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [FIELD_BITS-1:0]  i_p_x,
    input  logic [FIELD_BITS-1:0]  i_p_y,
    input  logic                   i_p_inf,
    input  logic [FIELD_BITS-1:0]  i_q_x,
    input  logic [FIELD_BITS-1:0]  i_q_y,
    input  logic                   i_q_inf,
    input  logic [SCALAR_BITS-1:0] i_scalar,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FIELD_BITS-1:0]  i_cfg_data,
    output logic [FIELD_BITS-1:0]  o_r_x,
    output logic [FIELD_BITS-1:0]  o_r_y,
    output logic                   o_r_inf,
    output logic                   o_done
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ecp_ctrl #(
        .FIELD_BITS  (FIELD_BITS),
        .SCALAR_BITS (SCALAR_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    // field arithmetic and point registers
    ecp_datapath #(
        .FIELD_BITS  (FIELD_BITS),
        .SCALAR_BITS (SCALAR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_p_x       (i_p_x),
        .i_p_y       (i_p_y),
        .i_p_inf     (i_p_inf),
        .i_q_x       (i_q_x),
        .i_q_y       (i_q_y),
        .i_q_inf     (i_q_inf),
        .i_scalar    (i_scalar),
        .o_r_x       (o_r_x),
        .o_r_y       (o_r_y),
        .o_r_inf     (o_r_inf),
        .o_done      (o_done)
    );

endmodule

FILE: rtl/ecp_datapath.sv
module ecp_datapath import ecp_pkg::*; #(
    parameter int FIELD_BITS  = FIELD_BITS_DEF,
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FIELD_BITS-1:0]  i_cfg_data,
    input  logic [FIELD_BITS-1:0]  i_p_x,
    input  logic [FIELD_BITS-1:0]  i_p_y,
    input  logic                   i_p_inf,
    input  logic [FIELD_BITS-1:0]  i_q_x,
    input  logic [FIELD_BITS-1:0]  i_q_y,
    input  logic                   i_q_inf,
    input  logic [SCALAR_BITS-1:0] i_scalar,
    output logic [FIELD_BITS-1:0]  o_r_x,
    output logic [FIELD_BITS-1:0]  o_r_y,
    output logic                   o_r_inf,
    output logic                   o_done
);

    localparam int FB  = FIELD_BITS;
    localparam int MCW = $clog2(FIELD_BITS + 1);

    logic [FB-1:0] r_ux, r_uy, r_wx, r_wy, r_qx, r_qy, r_a, r_s, r_t0, r_t1;
    logic          r_uinf, r_winf, r_qinf;
    logic [FB-1:0] r_e;
    logic [SCALAR_BITS-1:0] r_k;
    logic [FB-1:0] r_curve_a, r_modulus;
    logic [FB-1:0] r_mx, r_my, r_acc;
    logic [MCW-1:0] r_mcnt;
    logic [3:0]    r_mdst;
    logic          r_mbusy, r_mdone;
    logic [FB-1:0] r_out_x, r_out_y;
    logic          r_out_inf, r_done;

    logic [FB-1:0] va, vb, acc2, step, wr_val;
    logic          wr_en, mul_last;
    logic [3:0]    wr_dst;

    // modular add, both operands below p
    function automatic logic [FB-1:0] addm(input logic [FB-1:0] a, input logic [FB-1:0] b,
                                            input logic [FB-1:0] p);
        logic [FB:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[FB-1:0];
    endfunction

    // modular subtract, both operands below p
    function automatic logic [FB-1:0] subm(input logic [FB-1:0] a, input logic [FB-1:0] b,
                                            input logic [FB-1:0] p);
        logic [FB:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else        s = {1'b0, a} + {1'b0, p} - {1'b0, b};
        return s[FB-1:0];
    endfunction

    function automatic logic [FB-1:0] sel(input logic [3:0] code,
                                           input logic [FB-1:0] ux, input logic [FB-1:0] uy,
                                           input logic [FB-1:0] wx, input logic [FB-1:0] wy,
                                           input logic [FB-1:0] qx, input logic [FB-1:0] qy,
                                           input logic [FB-1:0] a,  input logic [FB-1:0] s,
                                           input logic [FB-1:0] t0, input logic [FB-1:0] t1);
        logic [FB-1:0] v;
        unique case (code)
            R_UX:    v = ux;
            R_UY:    v = uy;
            R_WX:    v = wx;
            R_WY:    v = wy;
            R_QX:    v = qx;
            R_QY:    v = qy;
            R_A:     v = a;
            R_S:     v = s;
            R_T0:    v = t0;
            R_T1:    v = t1;
            R_ONE:   v = {{(FB-1){1'b0}}, 1'b1};
            default: v = '0;
        endcase
        return v;
    endfunction

    // operand selection
    assign va = sel(i_cmd.sa, r_ux, r_uy, r_wx, r_wy, r_qx, r_qy, r_a, r_s, r_t0, r_t1);
    assign vb = sel(i_cmd.sb, r_ux, r_uy, r_wx, r_wy, r_qx, r_qy, r_a, r_s, r_t0, r_t1);

    // one multiplier bit per cycle: double, then add when the bit is set
    assign acc2     = addm(r_acc, r_acc, r_modulus);
    assign step     = r_my[FB-1] ? addm(acc2, r_mx, r_modulus) : acc2;
    assign mul_last = r_mbusy && (r_mcnt == MCW'(1));

    // register file write port
    always_comb begin
        wr_en  = 1'b0;
        wr_dst = i_cmd.dst;
        wr_val = va;
        if (mul_last) begin
            wr_en  = 1'b1;
            wr_dst = r_mdst;
            wr_val = step;
        end else begin
            case (i_cmd.op)
                OP_ADD: begin wr_en = 1'b1; wr_val = addm(va, vb, r_modulus); end
                OP_SUB: begin wr_en = 1'b1; wr_val = subm(va, vb, r_modulus); end
                OP_MOV: begin wr_en = 1'b1; wr_val = va; end
                default: wr_en = 1'b0;
            endcase
        end
    end

    // working registers and point flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_ux   <= i_p_x;
            r_uy   <= i_p_y;
            r_uinf <= i_p_inf;
            r_wx   <= i_q_x;
            r_wy   <= i_q_y;
            r_winf <= i_q_inf;
            r_qinf <= i_q_inf;
            r_a    <= r_curve_a;
            r_k    <= i_scalar;
        end else if (wr_en) begin
            case (wr_dst)
                R_UX:    r_ux <= wr_val;
                R_UY:    r_uy <= wr_val;
                R_WX:    r_wx <= wr_val;
                R_WY:    r_wy <= wr_val;
                R_QX:    r_qx <= wr_val;
                R_QY:    r_qy <= wr_val;
                R_A:     r_a  <= wr_val;
                R_S:     r_s  <= wr_val;
                R_T0:    r_t0 <= wr_val;
                R_T1:    r_t1 <= wr_val;
                default: ;
            endcase
        end else begin
            case (i_cmd.op)
                OP_UINF: r_uinf <= 1'b1;
                OP_UFIN: r_uinf <= 1'b0;
                OP_UFROMW: begin
                    r_ux   <= r_wx;
                    r_uy   <= r_wy;
                    r_uinf <= r_winf;
                end
                OP_SETWU: begin
                    r_wx   <= r_ux;
                    r_wy   <= r_uy;
                    r_winf <= r_uinf;
                end
                OP_SETWQ: begin
                    r_wx   <= r_qx;
                    r_wy   <= r_qy;
                    r_winf <= r_qinf;
                end
                OP_LDE: r_e <= r_modulus - FB'(2);
                OP_SHE: r_e <= {r_e[FB-2:0], 1'b0};
                OP_SHK: r_k <= {r_k[SCALAR_BITS-2:0], 1'b0};
                default: ;
            endcase
        end
    end

    // serial modular multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.op == OP_MUL && !r_mbusy) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= MCW'(FIELD_BITS);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - MCW'(1);
                if (mul_last) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL && !r_mbusy) begin
            r_mx   <= va;
            r_my   <= vb;
            r_acc  <= '0;
            r_mdst <= i_cmd.dst;
        end else if (r_mbusy) begin
            r_acc <= step;
            r_my  <= {r_my[FB-2:0], 1'b0};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_a <= '0;
            r_modulus <= FB'(MOD_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CURVE_A: r_curve_a <= i_cfg_data;
                CFG_MODULUS: r_modulus <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == OP_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out_x   <= r_uinf ? '0 : r_ux;
            r_out_y   <= r_uinf ? '0 : r_uy;
            r_out_inf <= r_uinf;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.mul_done = r_mdone;
        o_stat.u_inf    = r_uinf;
        o_stat.w_inf    = r_winf;
        o_stat.eqx      = (r_ux == r_wx);
        o_stat.eqy      = (r_uy == r_wy);
        o_stat.uy_zero  = (r_uy == '0);
        o_stat.p_small  = (r_modulus < FB'(2));
        o_stat.e_msb    = r_e[FB-1];
        o_stat.k_msb    = r_k[SCALAR_BITS-1];
    end

    assign o_r_x   = r_out_x;
    assign o_r_y   = r_out_y;
    assign o_r_inf = r_out_inf;
    assign o_done  = r_done;

    // multiplier completes only after running
    a_mdone_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mdone |-> $past(r_mbusy))
        else $error("multiplier done without a running product");

    // bit counter stays in range while a product runs
    a_mcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> (r_mcnt != '0 && r_mcnt <= MCW'(FIELD_BITS)))
        else $error("multiplier bit count out of range");

    // an infinite result reports zero coordinates
    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out_inf) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("infinite result with nonzero coordinates");

endmodule

FILE: rtl/ecp_ctrl.sv
module ecp_ctrl import ecp_pkg::*; #(
    parameter int FIELD_BITS  = FIELD_BITS_DEF,
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_operation,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    localparam int KCW = $clog2(SCALAR_BITS + 1);
    localparam int ICW = $clog2(FIELD_BITS + 1);

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_CHK    = 6'd1;
    localparam logic [5:0] ST_RED_A  = 6'd2;
    localparam logic [5:0] ST_RED_UX = 6'd3;
    localparam logic [5:0] ST_RED_UY = 6'd4;
    localparam logic [5:0] ST_RED_WX = 6'd5;
    localparam logic [5:0] ST_RED_WY = 6'd6;
    localparam logic [5:0] ST_CPQX   = 6'd7;
    localparam logic [5:0] ST_CPQY   = 6'd8;
    localparam logic [5:0] ST_DISP   = 6'd9;
    localparam logic [5:0] ST_MWAIT  = 6'd10;
    localparam logic [5:0] ST_OUT    = 6'd11;
    localparam logic [5:0] ST_MBIT   = 6'd12;
    localparam logic [5:0] ST_MADD   = 6'd13;
    localparam logic [5:0] ST_MSH    = 6'd14;
    localparam logic [5:0] ST_PA0    = 6'd15;
    localparam logic [5:0] ST_PD1    = 6'd16;
    localparam logic [5:0] ST_PD2    = 6'd17;
    localparam logic [5:0] ST_PD3    = 6'd18;
    localparam logic [5:0] ST_PD4    = 6'd19;
    localparam logic [5:0] ST_PC0    = 6'd20;
    localparam logic [5:0] ST_PC1    = 6'd21;
    localparam logic [5:0] ST_INV0   = 6'd22;
    localparam logic [5:0] ST_INV1   = 6'd23;
    localparam logic [5:0] ST_INVL   = 6'd24;
    localparam logic [5:0] ST_INVB   = 6'd25;
    localparam logic [5:0] ST_INVS   = 6'd26;
    localparam logic [5:0] ST_SLOPE  = 6'd27;
    localparam logic [5:0] ST_X0     = 6'd28;
    localparam logic [5:0] ST_X1     = 6'd29;
    localparam logic [5:0] ST_X2     = 6'd30;
    localparam logic [5:0] ST_Y0     = 6'd31;
    localparam logic [5:0] ST_Y1     = 6'd32;
    localparam logic [5:0] ST_Y2     = 6'd33;
    localparam logic [5:0] ST_Y3     = 6'd34;
    localparam logic [5:0] ST_Y4     = 6'd35;

    logic [5:0]     r_state, n_state;
    logic [5:0]     r_ret, n_ret;
    logic [5:0]     r_pret, n_pret;
    logic           r_op, n_op;
    logic [KCW-1:0] r_cnt, n_cnt;
    logic [ICW-1:0] r_icnt, n_icnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_pret  <= ST_IDLE;
            r_op    <= OPER_ADD;
            r_cnt   <= '0;
            r_icnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pret  <= n_pret;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
            r_icnt  <= n_icnt;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pret  = r_pret;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_icnt  = r_icnt;
        o_cmd   = '{op: OP_NOP, dst: R_ZERO, sa: R_ZERO, sb: R_ZERO};
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_op     = i_operation;
                    n_state  = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.p_small) begin
                    o_cmd.op = OP_UINF;
                    n_state  = ST_OUT;
                end else begin
                    n_state = ST_RED_A;
                end
            end
            // reduce every operand modulo p as 1 * x
            ST_RED_A: begin
                o_cmd = '{op: OP_MUL, dst: R_A, sa: R_ONE, sb: R_A};
                n_ret = ST_RED_UX; n_state = ST_MWAIT;
            end
            ST_RED_UX: begin
                o_cmd = '{op: OP_MUL, dst: R_UX, sa: R_ONE, sb: R_UX};
                n_ret = ST_RED_UY; n_state = ST_MWAIT;
            end
            ST_RED_UY: begin
                o_cmd = '{op: OP_MUL, dst: R_UY, sa: R_ONE, sb: R_UY};
                n_ret = ST_RED_WX; n_state = ST_MWAIT;
            end
            ST_RED_WX: begin
                o_cmd = '{op: OP_MUL, dst: R_WX, sa: R_ONE, sb: R_WX};
                n_ret = ST_RED_WY; n_state = ST_MWAIT;
            end
            ST_RED_WY: begin
                o_cmd = '{op: OP_MUL, dst: R_WY, sa: R_ONE, sb: R_WY};
                n_ret = ST_CPQX; n_state = ST_MWAIT;
            end
            ST_CPQX: begin
                o_cmd = '{op: OP_MOV, dst: R_QX, sa: R_WX, sb: R_ZERO};
                n_state = ST_CPQY;
            end
            ST_CPQY: begin
                o_cmd = '{op: OP_MOV, dst: R_QY, sa: R_WY, sb: R_ZERO};
                n_state = ST_DISP;
            end
            ST_DISP: begin
                if (r_op == OPER_ADD) begin
                    n_pret  = ST_OUT;
                    n_state = ST_PA0;
                end else begin
                    o_cmd.op = OP_UINF;
                    n_cnt    = KCW'(SCALAR_BITS);
                    n_state  = ST_MBIT;
                end
            end
            ST_MWAIT: begin
                if (i_stat.mul_done) n_state = r_ret;
            end
            // double-and-add, scalar msb first
            ST_MBIT: begin
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.op = OP_SETWU;
                    n_pret   = ST_MADD;
                    n_state  = ST_PA0;
                end
            end
            ST_MADD: begin
                if (i_stat.k_msb) begin
                    o_cmd.op = OP_SETWQ;
                    n_pret   = ST_MSH;
                    n_state  = ST_PA0;
                end else begin
                    n_state = ST_MSH;
                end
            end
            ST_MSH: begin
                o_cmd.op = OP_SHK;
                n_cnt    = r_cnt - KCW'(1);
                n_state  = ST_MBIT;
            end
            // point addition u = u + w, special cases first
            ST_PA0: begin
                if (i_stat.u_inf) begin
                    o_cmd.op = OP_UFROMW;
                    n_state  = r_pret;
                end else if (i_stat.w_inf) begin
                    n_state = r_pret;
                end else if (i_stat.eqx) begin
                    if (!i_stat.eqy || i_stat.uy_zero) begin
                        o_cmd.op = OP_UINF;
                        n_state  = r_pret;
                    end else begin
                        o_cmd = '{op: OP_MUL, dst: R_T0, sa: R_UX, sb: R_UX};
                        n_ret = ST_PD1; n_state = ST_MWAIT;
                    end
                end else begin
                    n_state = ST_PC0;
                end
            end
            // tangent: num = 3x^2 + a, den = 2y
            ST_PD1: begin
                o_cmd = '{op: OP_ADD, dst: R_T1, sa: R_T0, sb: R_T0};
                n_state = ST_PD2;
            end
            ST_PD2: begin
                o_cmd = '{op: OP_ADD, dst: R_T1, sa: R_T1, sb: R_T0};
                n_state = ST_PD3;
            end
            ST_PD3: begin
                o_cmd = '{op: OP_ADD, dst: R_T1, sa: R_T1, sb: R_A};
                n_state = ST_PD4;
            end
            ST_PD4: begin
                o_cmd = '{op: OP_ADD, dst: R_T0, sa: R_UY, sb: R_UY};
                n_state = ST_INV0;
            end
            // chord: num = wy - uy, den = wx - ux
            ST_PC0: begin
                o_cmd = '{op: OP_SUB, dst: R_T1, sa: R_WY, sb: R_UY};
                n_state = ST_PC1;
            end
            ST_PC1: begin
                o_cmd = '{op: OP_SUB, dst: R_T0, sa: R_WX, sb: R_UX};
                n_state = ST_INV0;
            end
            // s = den^(p-2) by square-and-multiply
            ST_INV0: begin
                o_cmd = '{op: OP_MOV, dst: R_S, sa: R_ONE, sb: R_ZERO};
                n_state = ST_INV1;
            end
            ST_INV1: begin
                o_cmd.op = OP_LDE;
                n_icnt   = ICW'(FIELD_BITS);
                n_state  = ST_INVL;
            end
            ST_INVL: begin
                if (r_icnt == '0) begin
                    n_state = ST_SLOPE;
                end else begin
                    o_cmd = '{op: OP_MUL, dst: R_S, sa: R_S, sb: R_S};
                    n_ret = ST_INVB; n_state = ST_MWAIT;
                end
            end
            ST_INVB: begin
                if (i_stat.e_msb) begin
                    o_cmd = '{op: OP_MUL, dst: R_S, sa: R_S, sb: R_T0};
                    n_ret = ST_INVS; n_state = ST_MWAIT;
                end else begin
                    n_state = ST_INVS;
                end
            end
            ST_INVS: begin
                o_cmd.op = OP_SHE;
                n_icnt   = r_icnt - ICW'(1);
                n_state  = ST_INVL;
            end
            // slope and new coordinates
            ST_SLOPE: begin
                o_cmd = '{op: OP_MUL, dst: R_S, sa: R_T1, sb: R_S};
                n_ret = ST_X0; n_state = ST_MWAIT;
            end
            ST_X0: begin
                o_cmd = '{op: OP_MUL, dst: R_T0, sa: R_S, sb: R_S};
                n_ret = ST_X1; n_state = ST_MWAIT;
            end
            ST_X1: begin
                o_cmd = '{op: OP_SUB, dst: R_T0, sa: R_T0, sb: R_UX};
                n_state = ST_X2;
            end
            ST_X2: begin
                o_cmd = '{op: OP_SUB, dst: R_T0, sa: R_T0, sb: R_WX};
                n_state = ST_Y0;
            end
            ST_Y0: begin
                o_cmd = '{op: OP_SUB, dst: R_T1, sa: R_UX, sb: R_T0};
                n_state = ST_Y1;
            end
            ST_Y1: begin
                o_cmd = '{op: OP_MUL, dst: R_T1, sa: R_S, sb: R_T1};
                n_ret = ST_Y2; n_state = ST_MWAIT;
            end
            ST_Y2: begin
                o_cmd = '{op: OP_SUB, dst: R_UY, sa: R_T1, sb: R_UY};
                n_state = ST_Y3;
            end
            ST_Y3: begin
                o_cmd = '{op: OP_MOV, dst: R_UX, sa: R_T0, sb: R_ZERO};
                n_state = ST_Y4;
            end
            ST_Y4: begin
                o_cmd.op = OP_UFIN;
                n_state  = r_pret;
            end
            ST_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // an accepted request makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    // the result stage always returns to idle
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> (r_state == ST_IDLE))
        else $error("result stage did not return to idle");

    // a finished product resumes at the saved return state
    a_mul_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWAIT && i_stat.mul_done) |=> (r_state == $past(r_ret)))
        else $error("wrong resume after product");

endmodule
